// ===== rtl/lvas_pkg.sv =====
// Shared constants, widths and control types of the local-variance adaptive smoother.
`timescale 1ns / 1ps
package lvas_pkg;

  localparam int WIDTH_MAX  = 1024;
  localparam int HEIGHT_MAX = 4096;
  localparam int RADIUS_MAX = 16;

  localparam int HIST_ROWS = 2 * RADIUS_MAX + 1;
  localparam int NUM_CH    = 3;

  localparam int XW  = $clog2(WIDTH_MAX);
  localparam int YW  = $clog2(HEIGHT_MAX);
  localparam int WW  = $clog2(WIDTH_MAX + 1);
  localparam int HW  = $clog2(HEIGHT_MAX + 1);
  localparam int RW  = $clog2(RADIUS_MAX + 1);
  localparam int SPW = $clog2(HIST_ROWS + 1);
  localparam int SLW = $clog2(HIST_ROWS);
  localparam int NW  = $clog2(HIST_ROWS * HIST_ROWS + 1);
  localparam int PCW = $clog2(WIDTH_MAX * HEIGHT_MAX + RADIUS_MAX * WIDTH_MAX + RADIUS_MAX + 1);

  // column and window sums of values and squares
  localparam int CVW   = $clog2(HIST_ROWS * 255 + 1);
  localparam int CQW   = $clog2(HIST_ROWS * 65025 + 1);
  localparam int SVW   = $clog2(HIST_ROWS * HIST_ROWS * 255 + 1);
  localparam int SQW   = $clog2(HIST_ROWS * HIST_ROWS * 65025 + 1);
  localparam int CSUMW = CVW + CQW;
  localparam int CRAMW = NUM_CH * CSUMW;

  // gain arithmetic
  localparam int DW    = 16;
  localparam int DNW   = DW + NW;
  localparam int PW    = NW + SQW;
  localparam int SDNW  = DNW + SVW;
  localparam int AVW   = PW + 8;
  localparam int DENW  = PW + 1;
  localparam int NUMW  = ((SDNW > AVW) ? SDNW : AVW) + 1;
  localparam int QUO_W = 9;
  localparam int DSHW  = DENW + QUO_W - 1;
  localparam int CMPW  = (NUMW > DSHW) ? NUMW : DSHW;
  localparam int CNTW  = $clog2(QUO_W);

  localparam int HAW = $clog2(HIST_ROWS * WIDTH_MAX);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA  = 2'd3;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;
  localparam logic [4:0]  RST_RADIUS = 5'd12;
  localparam logic [15:0] RST_DELTA  = 16'd100;

  localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

  typedef struct packed {
    logic       accept;
    logic       cfg_wr;
    logic       rd;
    logic       upd;
    logic       win;
    logic       pix;
    logic       m1;
    logic       m2;
    logic       m3;
    logic       m4;
    logic       div;
    logic       res_wr;
    logic       out_load;
    logic [1:0] ch;
  } lvas_cmd_t;

  typedef struct packed {
    logic drop_now;
    logic upd_now;
    logic out_now;
    logic has_out;
    logic interior;
    logic out_free;
  } lvas_status_t;

endpackage

// ===== rtl/local_variance_adaptive_smoother.sv =====
// Top level of the local-variance adaptive smoother (box-window Lee filter on BGR pixels).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall | op, blue_in, green_in, red_in
//  out     | source    | out_valid/out_stall | blue_out, green_out, red_out, frame_end
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. A dropped filler or a drain item with no result ends at acceptance;
// a pixel goes on through the store read, store update and window steps. A result then
// reads its pixel and, if interior, runs 3 channels of 4 arithmetic steps, a 9-step
// restoring divider and a write-back step, before the output step. A drain item with a
// result skips the store read and update. After reset and after each register write the
// input stalls through the settle states SET1 and SET2 while the frame constants settle;
// the stores need no clearing pass. A result waiting in the output register does not block
// the next item; only the final beat of a later result waits for it to be taken.
`timescale 1ns / 1ps
module local_variance_adaptive_smoother (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [7:0]                      blue_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      red_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      blue_out_o,
  output logic [7:0]                      green_out_o,
  output logic [7:0]                      red_out_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lvas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lvas_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lvas_pkg::*;

  lvas_cmd_t    cmd;
  lvas_status_t status;

  lvas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  lvas_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (op_i),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== rtl/lvas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lvas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lvas_ctrl.sv =====
// Sequencer for the smoother: item acceptance, sum update, gain arithmetic, result beat.
`timescale 1ns / 1ps
module lvas_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  cfg_valid_i,
  input  lvas_pkg::lvas_status_t status_i,
  output logic                  in_stall_o,
  output logic                  cfg_ready_o,
  output lvas_pkg::lvas_cmd_t   cmd_o
);
  import lvas_pkg::*;

  typedef enum logic [13:0] {
    ST_SET1 = 14'b00000000000001,
    ST_SET2 = 14'b00000000000010,
    ST_IDLE = 14'b00000000000100,
    ST_RD   = 14'b00000000001000,
    ST_UPD  = 14'b00000000010000,
    ST_WIN  = 14'b00000000100000,
    ST_PIX  = 14'b00000001000000,
    ST_M1   = 14'b00000010000000,
    ST_M2   = 14'b00000100000000,
    ST_M3   = 14'b00001000000000,
    ST_M4   = 14'b00010000000000,
    ST_DIV  = 14'b00100000000000,
    ST_NEXT = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        ch_q, ch_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;

  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    cmd_o.ch = ch_q;
    unique case (state_q)
      // let derived frame constants settle
      ST_SET1: state_d = ST_SET2;
      ST_SET2: state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_wr = 1'b1;
          state_d      = ST_SET1;
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.drop_now) begin
            state_d = ST_IDLE;
          end else if (status_i.upd_now) begin
            state_d = ST_RD;
          end else if (status_i.out_now) begin
            state_d = ST_WIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = status_i.has_out ? ST_PIX : ST_IDLE;
      end
      ST_PIX: begin
        cmd_o.pix = 1'b1;
        ch_d      = '0;
        state_d   = status_i.interior ? ST_M1 : ST_OUT;
      end
      ST_M1: begin
        cmd_o.m1 = 1'b1;
        state_d  = ST_M2;
      end
      ST_M2: begin
        cmd_o.m2 = 1'b1;
        state_d  = ST_M3;
      end
      ST_M3: begin
        cmd_o.m3 = 1'b1;
        state_d  = ST_M4;
      end
      ST_M4: begin
        cmd_o.m4 = 1'b1;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (cnt_q == CNTW'(QUO_W - 1)) begin
          state_d = ST_NEXT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_NEXT: begin
        cmd_o.res_wr = 1'b1;
        if (ch_q == CH_LAST) begin
          state_d = ST_OUT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_M1;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_SET1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SET1;
      ch_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/lvas_datapath.sv =====
// Datapath: registers, position counters, line and column stores, gain arithmetic, output beat.
`timescale 1ns / 1ps
module lvas_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lvas_pkg::lvas_cmd_t                  cmd_i,
  output lvas_pkg::lvas_status_t               status_o,
  input  logic [lvas_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lvas_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 op_i,
  input  logic [7:0]                           blue_in_i,
  input  logic [7:0]                           green_in_i,
  input  logic [7:0]                           red_in_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [7:0]                           blue_out_o,
  output logic [7:0]                           green_out_o,
  output logic [7:0]                           red_out_o,
  output logic                                 frame_end_o
);
  import lvas_pkg::*;

  function automatic logic [HAW-1:0] hist_addr(input logic [SLW-1:0] slot,
                                               input logic [XW-1:0] x);
    return HAW'(HAW'(slot) * HAW'(WIDTH_MAX) + HAW'(x));
  endfunction

  function automatic logic [SLW-1:0] slot_next(input logic [SLW-1:0] slot);
    return (slot == SLW'(HIST_ROWS - 1)) ? '0 : SLW'(slot + 1'b1);
  endfunction

  // configuration
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [4:0]  radius_q;
  logic [15:0] delta_q;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RW-1:0]  r_eff;
  logic [DW-1:0]  d_eff;
  logic [SPW-1:0] span;

  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > 32'(WIDTH_MAX)) w_eff = WW'(WIDTH_MAX);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if (32'(height_q) > 32'(HEIGHT_MAX)) h_eff = HW'(HEIGHT_MAX);
    else h_eff = HW'(height_q);
    if (32'(radius_q) > 32'(RADIUS_MAX)) r_eff = RW'(RADIUS_MAX);
    else r_eff = RW'(radius_q);
    d_eff = (delta_q == '0) ? DW'(1) : delta_q;
    span  = SPW'({r_eff, 1'b1});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      radius_q <= RST_RADIUS;
      delta_q  <= RST_DELTA;
    end else if (cmd_i.cfg_wr) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= 11'(cfg_data_i);
        REG_HEIGHT: height_q <= 13'(cfg_data_i);
        REG_RADIUS: radius_q <= 5'(cfg_data_i);
        REG_DELTA:  delta_q  <= cfg_data_i;
        default:    width_q  <= width_q;
      endcase
    end
  end

  // frame constants, re-derived every cycle
  logic [NW-1:0]  n_q;
  logic [DNW-1:0] dn_q;
  logic [PCW-1:0] lag_q, pix_q, end_q;

  always_ff @(posedge clk_i) begin
    n_q   <= NW'(NW'(span) * NW'(span));
    lag_q <= PCW'(PCW'(r_eff) * PCW'(w_eff) + PCW'(r_eff));
    pix_q <= PCW'(PCW'(w_eff) * PCW'(h_eff));
    end_q <= PCW'(pix_q + lag_q);
    dn_q  <= DNW'(DNW'(d_eff) * DNW'(n_q));
  end

  // positions of the incoming and the outgoing pixel
  logic [PCW-1:0] p_q, p_d, p_inc;
  logic [XW-1:0]  ix_q, ix_d, ox_q, ox_d;
  logic [YW-1:0]  iy_q, iy_d, oy_q, oy_d;
  logic [SLW-1:0] islot_q, islot_d, oslot_q, oslot_d;

  logic drop_now, upd_now, out_now, interior_now, fend_now;

  always_comb begin
    drop_now = (p_q < pix_q) && op_i;
    upd_now  = (p_q < pix_q) && !op_i;
    out_now  = !drop_now && (p_q >= lag_q);
    interior_now = (32'(w_eff) >= 32'(span)) && (32'(h_eff) >= 32'(span)) &&
                   (32'(oy_q) >= 32'(r_eff)) && (32'(oy_q) + 32'(r_eff) < 32'(h_eff)) &&
                   (32'(ox_q) >= 32'(r_eff)) && (32'(ox_q) + 32'(r_eff) < 32'(w_eff));
    fend_now = (32'(ox_q) + 1 == 32'(w_eff)) && (32'(oy_q) + 1 == 32'(h_eff));
    p_inc    = PCW'(p_q + 1'b1);
  end

  always_comb begin
    p_d = p_q; ix_d = ix_q; iy_d = iy_q; islot_d = islot_q;
    ox_d = ox_q; oy_d = oy_q; oslot_d = oslot_q;
    if (cmd_i.cfg_wr || (cmd_i.accept && !drop_now && p_inc >= end_q)) begin
      p_d = '0; ix_d = '0; iy_d = '0; islot_d = '0;
      ox_d = '0; oy_d = '0; oslot_d = '0;
    end else if (cmd_i.accept && !drop_now) begin
      p_d = p_inc;
      if (upd_now) begin
        if (32'(ix_q) + 1 == 32'(w_eff)) begin
          ix_d    = '0;
          iy_d    = YW'(iy_q + 1'b1);
          islot_d = slot_next(islot_q);
        end else begin
          ix_d = XW'(ix_q + 1'b1);
        end
      end
      if (out_now) begin
        if (32'(ox_q) + 1 == 32'(w_eff)) begin
          ox_d    = '0;
          oy_d    = YW'(oy_q + 1'b1);
          oslot_d = slot_next(oslot_q);
        end else begin
          ox_d = XW'(ox_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0; ix_q <= '0; iy_q <= '0; islot_q <= '0;
      ox_q <= '0; oy_q <= '0; oslot_q <= '0;
    end else begin
      p_q <= p_d; ix_q <= ix_d; iy_q <= iy_d; islot_q <= islot_d;
      ox_q <= ox_d; oy_q <= oy_d; oslot_q <= oslot_d;
    end
  end

  // item captured at accept
  logic [2:0][7:0] pin_q;
  logic [XW-1:0]   cx_q, oxl_q;
  logic [SLW-1:0]  cslot_q, osl_q;
  logic first_row_q, sub_row_q, first_col_q, sub_col_q;
  logic upd_q, has_out_q, interior_q, fend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pin_q       <= {red_in_i, green_in_i, blue_in_i};
      cx_q        <= ix_q;
      cslot_q     <= islot_q;
      first_row_q <= (iy_q == '0);
      sub_row_q   <= (32'(iy_q) >= 32'(span));
      first_col_q <= (ix_q == '0);
      sub_col_q   <= (32'(ix_q) >= 32'(span));
      oxl_q       <= ox_q;
      osl_q       <= oslot_q;
      upd_q       <= upd_now;
      has_out_q   <= out_now;
      interior_q  <= interior_now;
      fend_q      <= fend_now;
    end
  end

  // row that leaves the column window: (current slot - span) mod rows
  logic [SLW:0]   old_slot_w;
  logic [SLW-1:0] old_slot;

  always_comb begin
    old_slot_w = (SLW + 1)'((SLW + 1)'(cslot_q) + (SLW + 1)'(HIST_ROWS) - (SLW + 1)'(span));
    if (32'(old_slot_w) >= 32'(HIST_ROWS)) begin
      old_slot = SLW'(32'(old_slot_w) - 32'(HIST_ROWS));
    end else begin
      old_slot = SLW'(old_slot_w);
    end
  end

  // pixel history
  logic [23:0]    hist_rdata;
  logic [HAW-1:0] hist_raddr;

  assign hist_raddr = cmd_i.rd ? hist_addr(old_slot, cx_q) : hist_addr(osl_q, oxl_q);

  lvas_ram #(
    .WIDTH (24),
    .DEPTH (HIST_ROWS * WIDTH_MAX)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (hist_addr(cslot_q, cx_q)),
    .wdata_i (pin_q),
    .re_i    (cmd_i.rd || cmd_i.win),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // column sums, all three channels in one word
  logic [CRAMW-1:0] col_rdata, col_new, col_new_q;
  logic [XW-1:0]    col_raddr;

  assign col_raddr = cmd_i.rd ? cx_q : XW'(32'(cx_q) - 32'(span));

  lvas_ram #(
    .WIDTH (CRAMW),
    .DEPTH (WIDTH_MAX)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (cx_q),
    .wdata_i (col_new),
    .re_i    (cmd_i.rd || cmd_i.upd),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  always_comb begin
    logic [7:0]     nv, ov;
    logic [CVW-1:0] cv;
    logic [CQW-1:0] cq;
    for (int c = 0; c < NUM_CH; c++) begin
      nv = pin_q[c];
      ov = hist_rdata[8*c +: 8];
      cv = first_row_q ? '0 : col_rdata[c*CSUMW +: CVW];
      cq = first_row_q ? '0 : col_rdata[c*CSUMW + CVW +: CQW];
      cv = CVW'(cv + CVW'(nv));
      cq = CQW'(cq + CQW'(16'(nv) * 16'(nv)));
      if (sub_row_q) begin
        cv = CVW'(cv - CVW'(ov));
        cq = CQW'(cq - CQW'(16'(ov) * 16'(ov)));
      end
      col_new[c*CSUMW +: CSUMW] = {cq, cv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      col_new_q <= col_new;
    end
  end

  // window sums
  logic [2:0][SVW-1:0] ws_q;
  logic [2:0][SQW-1:0] wq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      wq_q <= '0;
    end else if (cmd_i.cfg_wr) begin
      ws_q <= '0;
      wq_q <= '0;
    end else if (cmd_i.win && upd_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ws_q[c] <= SVW'((first_col_q ? '0 : ws_q[c])
                   + SVW'(col_new_q[c*CSUMW +: CVW])
                   - (sub_col_q ? SVW'(col_rdata[c*CSUMW +: CVW]) : SVW'(0)));
        wq_q[c] <= SQW'((first_col_q ? '0 : wq_q[c])
                   + SQW'(col_new_q[c*CSUMW + CVW +: CQW])
                   - (sub_col_q ? SQW'(col_rdata[c*CSUMW + CVW +: CQW]) : SQW'(0)));
      end
    end
  end

  // gain: floor((S*d*N + A*v) / (A + d*N*N)), one channel at a time
  logic [2:0][7:0]   res_q;
  logic [SVW-1:0]    s_sel;
  logic [SQW-1:0]    q_sel;
  logic [7:0]        v_sel;
  logic [PW-1:0]     ss_q, nq_q, b_q, a_q;
  logic [SDNW-1:0]   sdn_q;
  logic [AVW-1:0]    av_q;
  logic [DENW-1:0]   den_q;
  logic [NUMW-1:0]   rem_q;
  logic [DSHW-1:0]   dsh_q;
  logic [QUO_W-1:0]  quo_q;

  assign s_sel = ws_q[cmd_i.ch];
  assign q_sel = wq_q[cmd_i.ch];
  assign v_sel = res_q[cmd_i.ch];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_q[c] <= hist_rdata[8*c +: 8];
      end
    end
    if (cmd_i.m1) begin
      ss_q  <= PW'(PW'(s_sel) * PW'(s_sel));
      nq_q  <= PW'(PW'(n_q) * PW'(q_sel));
      b_q   <= PW'(PW'(dn_q) * PW'(n_q));
      sdn_q <= SDNW'(SDNW'(dn_q) * SDNW'(s_sel));
    end
    if (cmd_i.m2) begin
      a_q <= PW'(nq_q - ss_q);
    end
    if (cmd_i.m3) begin
      av_q  <= AVW'(AVW'(a_q) * AVW'(v_sel));
      den_q <= DENW'(DENW'(a_q) + DENW'(b_q));
    end
    if (cmd_i.m4) begin
      rem_q <= NUMW'(NUMW'(sdn_q) + NUMW'(av_q));
      dsh_q <= DSHW'(DSHW'(den_q) << (QUO_W - 1));
      quo_q <= '0;
    end
    if (cmd_i.div) begin
      if (CMPW'(rem_q) >= CMPW'(dsh_q)) begin
        rem_q <= NUMW'(rem_q - NUMW'(dsh_q));
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.res_wr) begin
      res_q[cmd_i.ch] <= (32'(quo_q) > 255) ? 8'hFF : quo_q[7:0];
    end
  end

  // output register
  logic            out_valid_q;
  logic [2:0][7:0] out_res_q;
  logic            out_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_res_q  <= res_q;
      out_fend_q <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_res_q[0];
  assign green_out_o = out_res_q[1];
  assign red_out_o   = out_res_q[2];
  assign frame_end_o = out_fend_q;

  assign status_o.drop_now = drop_now;
  assign status_o.upd_now  = upd_now;
  assign status_o.out_now  = out_now;
  assign status_o.has_out  = has_out_q;
  assign status_o.interior = interior_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/lvas_checker.sv =====
// Port-level checks of the smoother, bound to its top level.
`timescale 1ns / 1ps
module lvas_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] blue_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] red_out_o,
  input logic       frame_end_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable({blue_out_o, green_out_o, red_out_o, frame_end_o}))
    else $error("result beat changed while stalled");

  // a register write holds off input while the frame constants settle
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken too soon after register write");

  // a new result appears only out of a busy sequence
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while block was idle");

  // an item and a register write never land on the same edge
  a_no_cfg_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(cfg_valid_i && cfg_ready_o))
    else $error("item and register write accepted together");

endmodule

bind local_variance_adaptive_smoother lvas_checker u_lvas_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the local-variance adaptive smoother.
`timescale 1ns / 1ps
module testbench;
  import lvas_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_SHOWN = 10;
  localparam int EXTREME_ITEMS = 64;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } smoothed_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_FILL} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            b, g, r;
    bit                    typed;
    smoothed_t             want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic op_i = 1'b0;
  logic [7:0] blue_in_i = '0, green_in_i = '0, red_in_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, frame_end_o, cfg_ready_o;
  logic [7:0] blue_out_o, green_out_o, red_out_o;

  local_variance_adaptive_smoother u_top (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the block's registers and stores
  int unsigned fw, fh, fr, fd;
  logic [23:0] hist_rows [WIDTH_MAX*HIST_ROWS];
  int unsigned col_vsum [3*WIDTH_MAX];
  int unsigned col_qsum [3*WIDTH_MAX];
  int unsigned win_vsum [3];
  int unsigned win_qsum [3];
  int unsigned item_pos;

  smoothed_t pending_pixels [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void clear_sums();
    foreach (col_vsum[i]) begin
      col_vsum[i] = 0;
      col_qsum[i] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      win_vsum[c] = 0;
      win_qsum[c] = 0;
    end
  endfunction

  function automatic void shadow_reset();
    fw = RST_WIDTH;
    fh = RST_HEIGHT;
    fr = RST_RADIUS;
    fd = RST_DELTA;
    foreach (hist_rows[i]) hist_rows[i] = '0;
    clear_sums();
    item_pos = 0;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WIDTH:  fw = val & 16'h7FF;
      REG_HEIGHT: fh = val & 16'h1FFF;
      REG_RADIUS: fr = val & 16'h1F;
      REG_DELTA:  fd = val;
      default: ;
    endcase
    item_pos = 0;
    clear_sums();
  endfunction

  // advance the shadow by one accepted beat; return 1 when a pixel comes out
  function automatic bit predict_smoothed(logic op, logic [7:0] b, logic [7:0] g,
                                          logic [7:0] r, output smoothed_t res);
    int unsigned w, h, rad, d, span, pixels, lag, p, y, x, q, ci;
    logic [23:0] pix, old;
    logic [7:0] chv [3];
    longint unsigned n, s, qs, a, den, v;
    bit interior;
    w = clip(fw, 1, WIDTH_MAX);
    h = clip(fh, 1, HEIGHT_MAX);
    rad = clip(fr, 0, RADIUS_MAX);
    d = clip(fd, 1, 65535);
    span = 2*rad + 1;
    pixels = w*h;
    lag = rad*w + rad;
    p = item_pos;
    res = '0;
    if (p < pixels) begin
      y = p / w;
      x = p % w;
      if (op) return 0;
      if (p == 0) clear_sums();
      pix = {r, g, b};
      for (int c = 0; c < 3; c++) begin
        ci = c*WIDTH_MAX + x;
        v = (pix >> (8*c)) & 8'hFF;
        col_vsum[ci] += v;
        col_qsum[ci] += v*v;
        if (y >= span) begin
          old = hist_rows[((y-span) % HIST_ROWS)*WIDTH_MAX + x];
          v = (old >> (8*c)) & 8'hFF;
          col_vsum[ci] -= v;
          col_qsum[ci] -= v*v;
        end
      end
      hist_rows[(y % HIST_ROWS)*WIDTH_MAX + x] = pix;
      for (int c = 0; c < 3; c++) begin
        ci = c*WIDTH_MAX + x;
        if (x == 0) begin
          win_vsum[c] = 0;
          win_qsum[c] = 0;
        end
        win_vsum[c] += col_vsum[ci];
        win_qsum[c] += col_qsum[ci];
        if (x >= span) begin
          win_vsum[c] -= col_vsum[ci-span];
          win_qsum[c] -= col_qsum[ci-span];
        end
      end
    end
    item_pos = p + 1;
    if (item_pos >= pixels + lag) item_pos = 0;
    if (p < lag) return 0;
    q = p - lag;
    y = q / w;
    x = q % w;
    pix = hist_rows[(y % HIST_ROWS)*WIDTH_MAX + x];
    interior = w >= span && h >= span && y >= rad && y + rad < h && x >= rad && x + rad < w;
    n = span*span;
    for (int c = 0; c < 3; c++) begin
      v = (pix >> (8*c)) & 8'hFF;
      if (interior) begin
        s = win_vsum[c];
        qs = win_qsum[c];
        a = n*qs - s*s;
        den = a + longint'(d)*n*n;
        v = (s*d*n + a*v) / den;
        if (v > 255) v = 255;
      end
      chv[c] = v[7:0];
    end
    res = '{blue: chv[0], green: chv[1], red: chv[2], last: (q == pixels-1)};
    return 1;
  endfunction

  task automatic push_item(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                           bit typed = 0, smoothed_t want = '0);
    smoothed_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    blue_in_i <= b;
    green_in_i <= g;
    red_in_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_smoothed(op, b, g, r, res)) pending_pixels.push_back(typed ? want : res);
  endtask

  // registers change only with nothing in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic configure(int w, int h, int rad, int d);
    wait_idle();
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_DELTA, CFG_DATA_W'(d));
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("local_variance_adaptive_smoother test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    smoothed_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{blue: blue_out_o, green: green_out_o, red: red_out_o, last: frame_end_o};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected beat %p", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row = '{kind: ROW_CFG, idx: idx, data: val, default: '0};
    return row;
  endfunction

  function automatic stim_row_t pix_row(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                        bit typed, bit last);
    stim_row_t row = '{kind: ROW_PIX, b: b, g: g, r: r, typed: typed, default: '0};
    row.want = '{blue: b, green: g, red: r, last: last};
    return row;
  endfunction

  initial begin
    stim_row_t plan [$];
    int pixels_sent, phase, w, h, rad, d, frames, span_items, cut, base;
    logic [7:0] c [3];
    bit flat;

    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel frame: every pixel comes straight back as the frame's last
    plan.push_back(cfg_row(REG_WIDTH, 16'd1));
    plan.push_back(cfg_row(REG_HEIGHT, 16'd1));
    plan.push_back(cfg_row(REG_RADIUS, 16'd0));
    plan.push_back(cfg_row(REG_DELTA, 16'd100));
    plan.push_back(pix_row(8'h00, 8'h00, 8'h00, 1, 1));
    plan.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 1, 1));
    plan.push_back('{kind: ROW_FILL, default: '0});
    plan.push_back(pix_row(8'hAA, 8'h55, 8'h0F, 1, 1));
    plan.push_back(cfg_row(REG_DELTA, 16'd0));
    plan.push_back(pix_row(8'h55, 8'hAA, 8'hF0, 1, 1));
    // 3x3 with R=1: one interior pixel, a pixel sent while draining
    plan.push_back(cfg_row(REG_WIDTH, 16'd3));
    plan.push_back(cfg_row(REG_HEIGHT, 16'd3));
    plan.push_back(cfg_row(REG_RADIUS, 16'd1));
    plan.push_back(cfg_row(REG_DELTA, 16'd1));
    plan.push_back(pix_row(8'h00, 8'hFF, 8'h10, 0, 0));
    plan.push_back(pix_row(8'hFF, 8'h00, 8'h20, 0, 0));
    plan.push_back(pix_row(8'h00, 8'hFF, 8'h30, 0, 0));
    plan.push_back('{kind: ROW_FILL, default: '0});
    plan.push_back(pix_row(8'hFF, 8'h00, 8'h40, 0, 0));
    plan.push_back(pix_row(8'h80, 8'h80, 8'h50, 0, 0));
    plan.push_back(pix_row(8'h00, 8'hFF, 8'h60, 0, 0));
    plan.push_back(pix_row(8'hFF, 8'h00, 8'h70, 0, 0));
    plan.push_back(pix_row(8'h00, 8'hFF, 8'h80, 0, 0));
    plan.push_back(pix_row(8'hFF, 8'h00, 8'h90, 0, 0));
    plan.push_back(pix_row(8'h12, 8'h34, 8'h56, 0, 0));
    repeat (3) plan.push_back('{kind: ROW_FILL, default: '0});

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(plan[i].idx, plan[i].data);
        end
        ROW_PIX:  push_item(1'b0, plan[i].b, plan[i].g, plan[i].r, plan[i].typed, plan[i].want);
        ROW_FILL: push_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
    end

    pixels_sent = 0;
    phase = 0;
    while (pixels_sent < 1500) begin
      case (phase)
        0: begin w = 33; h = 33; rad = 31; d = 65535; end
        1: begin w = 2047; h = 1; rad = 0; d = 7; end
        2: begin w = 1; h = 8191; rad = 2; d = 300; end
        3: begin w = 0; h = 0; rad = 0; d = 0; end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 10);
          rad = $urandom_range(0, 3);
          d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 400);
        end
      endcase
      // big extreme frames run without idling and are cut short to keep the run short
      send_idle_pct = (phase < 4) ? 0 : (phase % 4 == 1 ? 80 : (phase % 4 == 3 ? 11 : 0));
      stall_pct = (phase < 4) ? 0 : (phase % 4 == 2 ? 80 : (phase % 4 == 3 ? 11 : 0));
      configure(w, h, rad, d);
      frames = $urandom_range(1, 2);
      span_items = frames * (clip(w, 1, WIDTH_MAX) * clip(h, 1, HEIGHT_MAX) +
                             clip(rad, 0, RADIUS_MAX) * clip(w, 1, WIDTH_MAX) +
                             clip(rad, 0, RADIUS_MAX));
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span_items) : span_items;
      if (phase < 4 && cut > EXTREME_ITEMS) cut = EXTREME_ITEMS;
      flat = $urandom_range(0, 1);
      base = $urandom_range(0, 255);
      for (int k = 0; k < cut; k++) begin
        for (int ch = 0; ch < 3; ch++)
          c[ch] = 8'(flat ? clip(base + $urandom_range(0, 14), 7, 262) - 7
                          : $urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
          push_item(1'b1, c[0], c[1], c[2]);
          k--;
        end else begin
          push_item(1'b0, c[0], c[1], c[2]);
          pixels_sent++;
        end
      end
      phase++;
    end
    in_valid_i <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("local_variance_adaptive_smoother test passed");
    else $display("local_variance_adaptive_smoother test failed");
    $finish;
  end

endmodule
